[rtl/allocation_tracking_table_core_assert.svh]
// Assertion macros for the allocation tracking table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ALLOCATION_TRACKING_TABLE_CORE_ASSERT_SVH
`define ALLOCATION_TRACKING_TABLE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ATT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ATT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/att_pkg.sv]
// Shared constants, codes and controller/datapath interface types
// for the allocation tracking table. No dependencies.
package att_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 40;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int TOT_W    = 64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_FREED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_UNTRACKED = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_SCAN  = 3'b100
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic load_ignore;
        logic scan_en;
        logic commit_hit;
        logic commit_miss;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic ignore;
        logic hit;
        logic last;
    } stat_t;

endpackage

[rtl/att_ctrl.sv]
// Controller state machine for the allocation tracking table.
// Depends on att_pkg; drives the datapath through cmd_t, reads stat_t.
module att_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  att_pkg::stat_t stat,
    output att_pkg::cmd_t  cmd,
    output logic          busy
);
    import att_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (stat.ignore)
                    begin
                        cmd.load_ignore = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                // a hit on the final slot wins over the miss
                if (stat.hit)
                begin
                    cmd.commit_hit = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.last)
                begin
                    cmd.commit_miss = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/att_datapath.sv]
// Datapath for the allocation tracking table: slot memories, scan counter,
// running totals and result registers. Depends on att_pkg.
module att_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  att_pkg::cmd_t                 cmd,
    output att_pkg::stat_t                stat,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          opcode,
    input  logic [att_pkg::ADDR_W-1:0]    address,
    input  logic [att_pkg::SIZE_W-1:0]    block_size,
    output logic                          done,
    output logic [att_pkg::STATUS_W-1:0]  status,
    output logic [att_pkg::SLOT_W-1:0]    slot,
    output logic [att_pkg::SIZE_W-1:0]    entry_size,
    output logic [att_pkg::COUNT_W-1:0]   active_count,
    output logic [att_pkg::TOT_W-1:0]     usage_now,
    output logic [att_pkg::TOT_W-1:0]     usage_peak,
    output logic [att_pkg::TOT_W-1:0]     bytes_allocated,
    output logic [att_pkg::TOT_W-1:0]     bytes_freed
);
    import att_pkg::*;

    logic              valid_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0] addr_mem  [TABLE_ENTRIES];
    logic [SIZE_W-1:0] bytes_mem [TABLE_ENTRIES];

    logic [IDX_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  data_idx_reg;
    logic              data_ok_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [SIZE_W-1:0] rd_bytes_reg;

    logic              mon_reg;
    logic              op_reg;
    logic [ADDR_W-1:0] cap_addr_reg;
    logic [SIZE_W-1:0] cap_size_reg;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TOT_W-1:0]  alloc_reg, alloc_next;
    logic [TOT_W-1:0]  freed_reg, freed_next;
    logic [TOT_W-1:0]  use_reg, use_next;
    logic [TOT_W-1:0]  peak_reg, peak_next;

    logic              done_reg, done_next;
    status_t           status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic              is_alloc;
    logic              valid_we;
    logic [IDX_W-1:0]  valid_wa;
    logic              valid_wd;
    logic              entry_we;
    logic [TOT_W-1:0]  size_ext;
    logic [TOT_W-1:0]  freed_ext;
    logic [TOT_W-1:0]  use_add;
    logic [TOT_W-1:0]  use_sub;

    assign is_alloc = (op_reg == OP_ALLOC);

    // status back to the controller
    assign stat.clear_last = (scan_idx_reg == LAST_IDX);
    assign stat.ignore     = !mon_reg || (address == '0);
    assign stat.hit        = data_ok_reg &&
                             (is_alloc ? !rd_valid_reg
                                       : (rd_valid_reg && (rd_addr_reg == cap_addr_reg)));
    assign stat.last       = data_ok_reg && (data_idx_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mon_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            mon_reg <= cfg_wdata;
        end
    end

    // scan counter doubles as the clearing pointer after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            data_idx_reg <= '0;
            data_ok_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.clear_step || cmd.scan_en)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            data_ok_reg <= cmd.scan_en && !cmd.capture;
            if (cmd.scan_en)
            begin
                data_idx_reg <= scan_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= opcode;
            cap_addr_reg <= address;
            cap_size_reg <= block_size;
        end
    end

    assign valid_we = cmd.clear_step || cmd.commit_hit;
    assign valid_wa = cmd.clear_step ? scan_idx_reg : data_idx_reg;
    assign valid_wd = cmd.commit_hit && is_alloc;
    assign entry_we = cmd.commit_hit && is_alloc;

    always_ff @(posedge clk)
    begin
        if (valid_we)
        begin
            valid_mem[valid_wa] <= valid_wd;
        end
        rd_valid_reg <= valid_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            addr_mem[data_idx_reg]  <= cap_addr_reg;
            bytes_mem[data_idx_reg] <= cap_size_reg;
        end
        rd_addr_reg  <= addr_mem[scan_idx_reg];
        rd_bytes_reg <= bytes_mem[scan_idx_reg];
    end

    assign size_ext  = TOT_W'(cap_size_reg);
    assign freed_ext = TOT_W'(rd_bytes_reg);
    assign use_add   = use_reg + size_ext;
    assign use_sub   = use_reg - freed_ext;

    always_comb
    begin
        cnt_next   = cnt_reg;
        alloc_next = alloc_reg;
        freed_next = freed_reg;
        use_next   = use_reg;
        peak_next  = peak_reg;
        if (cmd.commit_hit)
        begin
            if (is_alloc)
            begin
                cnt_next   = cnt_reg + CNT_W'(1);
                alloc_next = alloc_reg + size_ext;
                use_next   = use_add;
                if (use_add > peak_reg)
                begin
                    peak_next = use_add;
                end
            end
            else
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                freed_next = freed_reg + freed_ext;
                use_next   = use_sub;
            end
        end
    end

    always_comb
    begin
        done_next   = cmd.commit_hit || cmd.commit_miss || cmd.load_ignore;
        status_next = ST_IGNORED;
        slot_next   = '0;
        size_next   = '0;
        if (cmd.commit_hit)
        begin
            status_next = is_alloc ? ST_STORED : ST_FREED;
            slot_next   = SLOT_W'(data_idx_reg);
            size_next   = is_alloc ? cap_size_reg : rd_bytes_reg;
        end
        else if (cmd.commit_miss)
        begin
            status_next = is_alloc ? ST_FULL : ST_UNTRACKED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            alloc_reg <= '0;
            freed_reg <= '0;
            use_reg   <= '0;
            peak_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            alloc_reg <= alloc_next;
            freed_reg <= freed_next;
            use_reg   <= use_next;
            peak_reg  <= peak_next;
            done_reg  <= done_next;
        end
    end

    // hold the result fields between beats
    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            size_reg   <= size_next;
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign slot            = slot_reg;
    assign entry_size      = size_reg;
    assign active_count    = COUNT_W'(cnt_reg);
    assign usage_now       = use_reg;
    assign usage_peak      = peak_reg;
    assign bytes_allocated = alloc_reg;
    assign bytes_freed     = freed_reg;

endmodule

[rtl/allocation_tracking_table_core.sv]
// Top level of the allocation tracking table: controller plus datapath.
// Depends on att_pkg, att_ctrl, att_datapath and the assertion macro header.
//
// Events enter on start while busy is low; each gives one result beat on done,
// held for exactly one cycle, which the receiver must take as it comes. An
// event that is ignored (monitoring off or null address) is answered in the
// next cycle and leaves busy low. Any other event walks the slot memory one
// slot per clock on its single read port until it finds a free slot (alloc)
// or the matching address (free), or passes the last slot; done is registered
// from the commit and rises as busy falls. After reset busy stays high while
// the valid bits are cleared; configuration writes are taken at any time.
`include "allocation_tracking_table_core_assert.svh"

module allocation_tracking_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          opcode,
    input  logic [att_pkg::ADDR_W-1:0]    address,
    input  logic [att_pkg::SIZE_W-1:0]    block_size,
    output logic                          done,
    output logic [att_pkg::STATUS_W-1:0]  status,
    output logic [att_pkg::SLOT_W-1:0]    slot,
    output logic [att_pkg::SIZE_W-1:0]    entry_size,
    output logic [att_pkg::COUNT_W-1:0]   active_count,
    output logic [att_pkg::TOT_W-1:0]     usage_now,
    output logic [att_pkg::TOT_W-1:0]     usage_peak,
    output logic [att_pkg::TOT_W-1:0]     bytes_allocated,
    output logic [att_pkg::TOT_W-1:0]     bytes_freed
);
    import att_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    att_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    att_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .opcode          (opcode),
        .address         (address),
        .block_size      (block_size),
        .done            (done),
        .status          (status),
        .slot            (slot),
        .entry_size      (entry_size),
        .active_count    (active_count),
        .usage_now       (usage_now),
        .usage_peak      (usage_peak),
        .bytes_allocated (bytes_allocated),
        .bytes_freed     (bytes_freed)
    );

    `ATT_ASSERT_NOW(a_done_not_busy, done, !busy, "result beat while scanning")
    `ATT_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted beat dropped")
    `ATT_ASSERT_NEXT(a_commit_done, cmd.commit_hit || cmd.commit_miss, done, "commit without beat")
    `ATT_ASSERT_NOW(a_peak_tracks, done && (status == ST_STORED), usage_peak >= usage_now, "peak below usage")

endmodule

[tb/allocation_tracking_table_core_test.sv]
// Self-checking testbench for allocation_tracking_table_core: directed,
// random, monitor-off and table-full tests against an internal predictor
// of the slot table. Depends on att_pkg and the RTL of the block only.
module allocation_tracking_table_core_test;
    import att_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int LIVE_CAP    = 40;
    localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
    localparam logic [SIZE_W-1:0] SIZE_TOP = '1;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic [SIZE_W-1:0]    entry_size;
        logic [COUNT_W-1:0]   active_count;
        logic [TOT_W-1:0]     usage_now;
        logic [TOT_W-1:0]     usage_peak;
        logic [TOT_W-1:0]     bytes_allocated;
        logic [TOT_W-1:0]     bytes_freed;
    } reply_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic                  cfg_wdata  = 1'b0;
    logic                  opcode     = OP_ALLOC;
    logic [ADDR_W-1:0]     address    = '0;
    logic [SIZE_W-1:0]     block_size = '0;
    logic                  busy;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [SIZE_W-1:0]     entry_size;
    logic [COUNT_W-1:0]    active_count;
    logic [TOT_W-1:0]      usage_now;
    logic [TOT_W-1:0]      usage_peak;
    logic [TOT_W-1:0]      bytes_allocated;
    logic [TOT_W-1:0]      bytes_freed;

    // Predictor state: shadow of the slot table and its totals
    bit                    monitor_on = 1'b1;
    bit                    tbl_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0]     tbl_addr  [TABLE_ENTRIES];
    logic [SIZE_W-1:0]     tbl_bytes [TABLE_ENTRIES];
    bit [COUNT_W-1:0]      live_count;
    bit [TOT_W-1:0]        total_alloc;
    bit [TOT_W-1:0]        released_sum;
    bit [TOT_W-1:0]        used_now;
    bit [TOT_W-1:0]        used_peak;

    reply_t                predicted_replies [$];
    reply_t                oldest_reply;
    int                    error_count;
    int                    cycle_count;
    int                    stored_n, freed_n, full_n, untracked_n, ignored_n;

    allocation_tracking_table_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .opcode          (opcode),
        .address         (address),
        .block_size      (block_size),
        .done            (done),
        .status          (status),
        .slot            (slot),
        .entry_size      (entry_size),
        .active_count    (active_count),
        .usage_now       (usage_now),
        .usage_peak      (usage_peak),
        .bytes_allocated (bytes_allocated),
        .bytes_freed     (bytes_freed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 40)
            $display("MISMATCH at %0t: %s got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Apply one event to the shadow table and return the reply it should give
    function automatic reply_t track_event(input logic op, input logic [ADDR_W-1:0] addr,
                                           input logic [SIZE_W-1:0] size);
        reply_t r;
        bit     found;
        int     k;
        r = '0;
        found = 1'b0;
        if (!monitor_on || addr == '0)
            r.status = ST_IGNORED;
        else if (op == OP_ALLOC)
        begin
            r.status = ST_FULL;
            for (k = 0; k < TABLE_ENTRIES && !found; k++)
            begin
                if (!tbl_valid[k])
                begin
                    found        = 1'b1;
                    tbl_valid[k] = 1'b1;
                    tbl_addr[k]  = addr;
                    tbl_bytes[k] = size;
                    live_count++;
                    total_alloc += TOT_W'(size);
                    used_now    += TOT_W'(size);
                    if (used_now > used_peak)
                        used_peak = used_now;
                    r.status     = ST_STORED;
                    r.slot       = SLOT_W'(k);
                    r.entry_size = size;
                end
            end
        end
        else
        begin
            r.status = ST_UNTRACKED;
            for (k = 0; k < TABLE_ENTRIES && !found; k++)
            begin
                if (tbl_valid[k] && tbl_addr[k] == addr)
                begin
                    found        = 1'b1;
                    tbl_valid[k] = 1'b0;
                    if (live_count != 0)
                        live_count--;
                    released_sum += TOT_W'(tbl_bytes[k]);
                    used_now     -= TOT_W'(tbl_bytes[k]);
                    r.status     = ST_FREED;
                    r.slot       = SLOT_W'(k);
                    r.entry_size = tbl_bytes[k];
                end
            end
        end
        r.active_count    = live_count;
        r.usage_now       = used_now;
        r.usage_peak      = used_peak;
        r.bytes_allocated = total_alloc;
        r.bytes_freed     = released_sum;
        return r;
    endfunction

    // Result beats cannot be held off: take each one as it comes
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_replies.size() == 0)
                report_mismatch("reply with nothing pending, status", 64'(status), '0);
            else
            begin
                oldest_reply = predicted_replies.pop_front();
                if (status !== oldest_reply.status)
                    report_mismatch("status", 64'(status), 64'(oldest_reply.status));
                if (slot !== oldest_reply.slot)
                    report_mismatch("slot", 64'(slot), 64'(oldest_reply.slot));
                if (entry_size !== oldest_reply.entry_size)
                    report_mismatch("entry_size", 64'(entry_size),
                                    64'(oldest_reply.entry_size));
                if (active_count !== oldest_reply.active_count)
                    report_mismatch("active_count", 64'(active_count),
                                    64'(oldest_reply.active_count));
                if (usage_now !== oldest_reply.usage_now)
                    report_mismatch("usage_now", usage_now, oldest_reply.usage_now);
                if (usage_peak !== oldest_reply.usage_peak)
                    report_mismatch("usage_peak", usage_peak, oldest_reply.usage_peak);
                if (bytes_allocated !== oldest_reply.bytes_allocated)
                    report_mismatch("bytes_allocated", bytes_allocated,
                                    oldest_reply.bytes_allocated);
                if (bytes_freed !== oldest_reply.bytes_freed)
                    report_mismatch("bytes_freed", bytes_freed, oldest_reply.bytes_freed);
                case (oldest_reply.status)
                    ST_STORED:    stored_n++;
                    ST_FREED:     freed_n++;
                    ST_FULL:      full_n++;
                    ST_UNTRACKED: untracked_n++;
                    default:      ignored_n++;
                endcase
            end
        end
    end

    // Called just after a rising edge; returns at the edge that takes the beat
    task automatic send_event(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [SIZE_W-1:0] size);
        start      <= 1'b1;
        opcode     <= op;
        address    <= addr;
        block_size <= size;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted_replies.push_back(track_event(op, addr, size));
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_pause(input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
            pause_sender(($urandom_range(0, 7) == 0) ? $urandom_range(5, 60)
                                                     : $urandom_range(1, 4));
    endtask

    // Hold the sender until every pending reply has arrived
    task automatic drain_replies();
        start <= 1'b0;
        do
            @(posedge clk);
        while (predicted_replies.size() != 0);
    endtask

    task automatic write_monitor(input bit enable);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= enable;
        @(posedge clk);
        monitor_on = enable;
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(0, 15))
            0:       a = ADDR_TOP;
            1, 2:    a = ADDR_W'($urandom_range(1, 255));
            default: a = ADDR_W'({$urandom(), $urandom()});
        endcase
        if (a == '0)
            a = ADDR_W'(1);
        return a;
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SIZE_TOP;
            2, 3:    return SIZE_W'($urandom_range(1, 4096));
            default: return SIZE_W'({$urandom(), $urandom()});
        endcase
    endfunction

    // One event, or a free/alloc pair for a realloc, with random content
    task automatic random_step(input int idle_pct, output int items);
        int live_slots [$];
        int pick;
        int k;
        for (k = 0; k < TABLE_ENTRIES; k++)
            if (tbl_valid[k])
                live_slots.push_back(k);
        pick  = $urandom_range(0, 99);
        items = 1;
        if (pick < 5)
            send_event(logic'($urandom_range(0, 1)), '0, random_size());
        else if (pick < 8)
            send_event(OP_FREE, random_addr(), random_size());
        else if (pick < 12 && live_slots.size() != 0)
            send_event(OP_ALLOC, tbl_addr[live_slots[$urandom_range(0, live_slots.size() - 1)]],
                       random_size());
        else if (pick < 22 && live_slots.size() != 0)
        begin
            send_event(OP_FREE, tbl_addr[live_slots[$urandom_range(0, live_slots.size() - 1)]],
                       random_size());
            maybe_pause(idle_pct);
            send_event(OP_ALLOC, random_addr(), random_size());
            items = 2;
        end
        else if ((pick < 60 && live_slots.size() < LIVE_CAP) || live_slots.size() == 0)
            send_event(OP_ALLOC, random_addr(), random_size());
        else
            send_event(OP_FREE, tbl_addr[live_slots[$urandom_range(0, live_slots.size() - 1)]],
                       random_size());
        maybe_pause(idle_pct);
    endtask

    task automatic test_directed_basics();
        send_event(OP_ALLOC, ADDR_TOP, SIZE_TOP);
        send_event(OP_ALLOC, ADDR_W'(1), '0);
        send_event(OP_ALLOC, '0, SIZE_W'(5));
        send_event(OP_FREE, '0, SIZE_TOP);
        // duplicate addresses: each free takes the lowest matching slot
        send_event(OP_ALLOC, 48'h8000_0000_0001, SIZE_W'(1));
        send_event(OP_ALLOC, 48'h8000_0000_0001, 40'h80_0000_0000);
        send_event(OP_FREE, 48'h8000_0000_0001, SIZE_TOP);
        pause_sender(3);
        send_event(OP_FREE, 48'h8000_0000_0001, '0);
        send_event(OP_FREE, 48'h8000_0000_0001, '0);
        // peak holds across the free and the smaller alloc after it
        send_event(OP_FREE, ADDR_TOP, '0);
        send_event(OP_ALLOC, 48'h0000_0000_1000, SIZE_W'(16));
        send_event(OP_FREE, ADDR_W'(1), '0);
        drain_replies();
    endtask

    task automatic test_monitor_off(input int events);
        int items;
        write_monitor(1'b0);
        repeat (events) random_step(30, items);
        write_monitor(1'b1);
    endtask

    task automatic test_random(input int events, input int idle_pct);
        int sent;
        int items;
        sent = 0;
        while (sent < events)
        begin
            random_step(idle_pct, items);
            sent += items;
        end
        drain_replies();
    endtask

    task automatic test_table_full();
        int k;
        drain_replies();
        while (live_count < TABLE_ENTRIES)
        begin
            send_event(OP_ALLOC, random_addr(), random_size());
            maybe_pause(5);
        end
        send_event(OP_ALLOC, random_addr(), random_size());
        send_event(OP_FREE, 48'h1234_5678_9ABC, '0);
        send_event(OP_ALLOC, '0, SIZE_TOP);
        // realloc into a random slot, then into the last slot
        k = $urandom_range(0, TABLE_ENTRIES - 1);
        send_event(OP_FREE, tbl_addr[k], '0);
        send_event(OP_ALLOC, random_addr(), random_size());
        send_event(OP_FREE, tbl_addr[TABLE_ENTRIES - 1], '0);
        send_event(OP_ALLOC, ADDR_TOP, SIZE_TOP);
        send_event(OP_ALLOC, random_addr(), random_size());
        drain_replies();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_monitor(1'b1);

        test_directed_basics();
        test_monitor_off(4);
        test_random(193, 27);
        test_monitor_off(6);
        test_random(193, 80);
        test_monitor_off(6);
        test_random(194, 0);
        test_table_full();

        drain_replies();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (predicted_replies.size() != 0)
            report_mismatch("replies never arrived, count", 64'(predicted_replies.size()), '0);

        $display("Checked %0d replies: %0d stored, %0d freed, %0d full, %0d untracked, %0d ignored",
                 stored_n + freed_n + full_n + untracked_n + ignored_n,
                 stored_n, freed_n, full_n, untracked_n, ignored_n);
        $display("Ran three sender idling profiles, monitoring on and off, a full %0d-slot table",
                 TABLE_ENTRIES);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
